// ===== rtl/gcne_pkg.sv =====
// shared types, constants and helpers for the grid neighbor cell enumerator
package gcne_pkg;

    localparam int MAX_CELLS_PER_AXIS = 256;
    localparam int COORD_W            = 8;
    localparam int CNT_W              = 9;
    localparam int ID_W               = 24;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
    } t_query;

    typedef struct packed {
        logic [ID_W-1:0] neighbor_id;
        logic            is_last;
        logic            out_of_grid;
        logic            on_low_x;
        logic            on_low_y;
        logic            on_low_z;
        logic            on_high_x;
        logic            on_high_y;
        logic            on_high_z;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic step;
        logic err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic oog;
        logic last;
    } t_sts;

    // counts above the axis limit saturate
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_CELLS_PER_AXIS);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== rtl/gcne_ctrl.sv =====
// controller state machine for the grid neighbor cell enumerator
module gcne_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gcne_pkg::t_sts i_sts,
    output gcne_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import gcne_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                // a query outside the grid ends here with its single error result
                if (i_sts.oog) begin
                    o_cmd.err = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/gcne_dp.sv =====
// datapath: config registers, neighbor walk counters, id accumulation, result register
module gcne_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gcne_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcne_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  gcne_pkg::t_query               i_query,
    input  gcne_pkg::t_cmd                 i_cmd,
    output gcne_pkg::t_sts                 o_sts,
    output logic                           o_strobe,
    output gcne_pkg::t_result              o_result
);
    import gcne_pkg::*;

    logic [CNT_W-1:0]   r_cells_x, r_cells_y, r_cells_z;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [CNT_W-1:0]   r_nx, r_ny, r_nz;
    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [ID_W-1:0]    r_nynz, r_xbase, r_ybase, r_ybase0;
    logic               r_valid;
    t_result            r_res;

    logic [COORD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic [2*CNT_W-1:0]         w_nynz;
    logic [COORD_W+CNT_W-1:0]   w_ybase0;
    logic [COORD_W+ID_W-1:0]    w_xbase0;
    logic [ID_W-1:0]            w_id;
    logic                       w_oog;
    logic                       w_last;
    logic                       z_wrap, y_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CNT_W'(1);
            r_cells_y <= CNT_W'(1);
            r_cells_z <= CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELLS_X: r_cells_x <= i_cfg_data;
                CFG_CELLS_Y: r_cells_y <= i_cfg_data;
                CFG_CELLS_Z: r_cells_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // neighborhood bounds per axis, clipped to the grid
    always_comb begin
        lo_x = (r_x == '0) ? r_x : r_x - COORD_W'(1);
        lo_y = (r_y == '0) ? r_y : r_y - COORD_W'(1);
        lo_z = (r_z == '0) ? r_z : r_z - COORD_W'(1);
        hi_x = (({1'b0, r_x} + CNT_W'(1)) < r_nx) ? r_x + COORD_W'(1) : r_x;
        hi_y = (({1'b0, r_y} + CNT_W'(1)) < r_ny) ? r_y + COORD_W'(1) : r_y;
        hi_z = (({1'b0, r_z} + CNT_W'(1)) < r_nz) ? r_z + COORD_W'(1) : r_z;
    end

    assign w_nynz   = r_ny * r_nz;
    assign w_ybase0 = lo_y * r_nz;
    assign w_xbase0 = r_px * r_nynz;
    assign w_id     = r_xbase + r_ybase + ID_W'(r_pz);
    assign w_oog    = ({1'b0, r_x} >= r_nx) || ({1'b0, r_y} >= r_ny) || ({1'b0, r_z} >= r_nz);
    assign z_wrap   = (r_pz == hi_z);
    assign y_wrap   = (r_py == hi_y);
    assign w_last   = (r_px == hi_x) && y_wrap && z_wrap;

    assign o_sts.oog  = w_oog;
    assign o_sts.last = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_query.cell_x;
            r_y  <= i_query.cell_y;
            r_z  <= i_query.cell_z;
            r_nx <= eff_count(r_cells_x);
            r_ny <= eff_count(r_cells_y);
            r_nz <= eff_count(r_cells_z);
        end
        if (i_cmd.mul1) begin
            r_nynz   <= ID_W'(w_nynz);
            r_ybase0 <= ID_W'(w_ybase0);
            r_ybase  <= ID_W'(w_ybase0);
            r_px     <= lo_x;
            r_py     <= lo_y;
            r_pz     <= lo_z;
        end
        if (i_cmd.mul2) begin
            r_xbase <= w_xbase0[ID_W-1:0];
        end
        if (i_cmd.step) begin
            // z runs fastest, then y, then x
            if (z_wrap) begin
                r_pz <= lo_z;
                if (y_wrap) begin
                    r_py    <= lo_y;
                    r_ybase <= r_ybase0;
                    r_px    <= r_px + COORD_W'(1);
                    r_xbase <= r_xbase + r_nynz;
                end else begin
                    r_py    <= r_py + COORD_W'(1);
                    r_ybase <= r_ybase + ID_W'(r_nz);
                end
            end else begin
                r_pz <= r_pz + COORD_W'(1);
            end
        end
        if (i_cmd.step) begin
            r_res.neighbor_id <= w_id;
            r_res.is_last     <= w_last;
            r_res.out_of_grid <= 1'b0;
            r_res.on_low_x    <= (r_x == '0);
            r_res.on_low_y    <= (r_y == '0);
            r_res.on_low_z    <= (r_z == '0);
            r_res.on_high_x   <= ({1'b0, r_x} == r_nx - CNT_W'(1));
            r_res.on_high_y   <= ({1'b0, r_y} == r_ny - CNT_W'(1));
            r_res.on_high_z   <= ({1'b0, r_z} == r_nz - CNT_W'(1));
        end else if (i_cmd.err) begin
            r_res.neighbor_id <= '0;
            r_res.is_last     <= 1'b1;
            r_res.out_of_grid <= 1'b1;
            r_res.on_low_x    <= 1'b0;
            r_res.on_low_y    <= 1'b0;
            r_res.on_low_z    <= 1'b0;
            r_res.on_high_x   <= 1'b0;
            r_res.on_high_y   <= 1'b0;
            r_res.on_high_z   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step | i_cmd.err;
        end
    end

    assign o_strobe = r_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/grid_cell_neighbor_enum_core.sv =====
// top level of the 3d uniform grid neighbor cell enumerator
//
// usage: program cells_x/y/z (index 0/1/2) through the write port while the
// block is idle; each count saturates at 256, a count of zero puts every
// query outside the grid. a query transfers at a clock edge with start high
// and busy low. the block then walks the clipped 3x3x3 neighborhood in
// dx, dy, dz order (dz fastest) and puts one linear id per cycle on o_result,
// marked by o_strobe; the final one carries is_last.
// setup: S_MUL1 forms ny*nz and S_MUL2 the x base product before the walk.
// the first result is registered by the first walk step, and the results
// (1 to 27) follow back to back; busy falls in the cycle that shows the
// final result. a query outside the grid gives a single error result.
// the walk counter steps once per cycle, which sets the throughput.
// reset restores all counts to 1 and drops busy and the strobe.
// the receiver cannot stall: every result is present for exactly one cycle.
module grid_cell_neighbor_enum_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  gcne_pkg::t_query               i_query,
    output logic                           o_strobe,
    output gcne_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [gcne_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcne_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gcne_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    gcne_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    gcne_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_query    (i_query),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/gcne_chk.sv =====
// port-level checker for the grid neighbor cell enumerator, bound to the top level
module gcne_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input gcne_pkg::t_result o_result
);
    import gcne_pkg::*;

    // results only come from a query in progress
    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a query in progress");

    // a fresh transfer is never followed at once by a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result one cycle after query transfer");

    // results of one query come back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.is_last) |=> o_strobe)
        else $error("gap inside a result burst");

    // going idle coincides with the final result
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.is_last))
        else $error("busy dropped without a final result");

    // an error result is a lone, final, zero id
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_of_grid) |->
            (o_result.is_last && o_result.neighbor_id == '0))
        else $error("malformed out-of-grid result");

endmodule

bind grid_cell_neighbor_enum_core gcne_chk u_gcne_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/gcne_checker.sv =====
// checker for the grid neighbor enumerator: predicts every neighbor id of a query and compares
`timescale 1ns / 1ps
module gcne_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  gcne_pkg::t_query                i_query,
    input  logic                            i_strobe,
    input  gcne_pkg::t_result               i_result,
    input  logic                            i_cfg_we,
    input  logic [gcne_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gcne_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_done,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results_seen
);
    import gcne_pkg::*;

    // shadow copies of the count registers, raw as written
    logic [CNT_W-1:0] shadow_x;
    logic [CNT_W-1:0] shadow_y;
    logic [CNT_W-1:0] shadow_z;
    t_result          expected_cells[$];
    t_result          want;
    logic             done_seen;

    task automatic report(input string msg);
        if (o_fail_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic enqueue(input t_result r);
        expected_cells = {expected_cells, r};
    endtask

    task automatic check_field(input string name, input int got, input int wanted);
        if (got != wanted) begin
            report($sformatf("%s got %0d, wanted %0d", name, got, wanted));
        end
    endtask

    function automatic int clip_count(input logic [CNT_W-1:0] raw);
        return (int'(raw) > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : int'(raw);
    endfunction

    // walk the clipped 3x3x3 block, dz fastest, and queue one result per cell (one error result if outside)
    task automatic predict_neighbors(input t_query q);
        int      nx, ny, nz;
        int      x, y, z;
        int      px, py, pz;
        int      id;
        t_result nbr;
        t_result held;
        bit      have_held;
        nx = clip_count(shadow_x);
        ny = clip_count(shadow_y);
        nz = clip_count(shadow_z);
        x = int'(q.cell_x);
        y = int'(q.cell_y);
        z = int'(q.cell_z);
        nbr = '0;
        held = '0;
        have_held = 1'b0;
        if (x >= nx || y >= ny || z >= nz) begin
            nbr.is_last = 1'b1;
            nbr.out_of_grid = 1'b1;
            enqueue(nbr);
            return;
        end
        nbr.on_low_x  = (x == 0);
        nbr.on_low_y  = (y == 0);
        nbr.on_low_z  = (z == 0);
        nbr.on_high_x = (x == nx - 1);
        nbr.on_high_y = (y == ny - 1);
        nbr.on_high_z = (z == nz - 1);
        for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dz = -1; dz <= 1; dz++) begin
                    px = x + dx;
                    py = y + dy;
                    pz = z + dz;
                    if (px < 0 || py < 0 || pz < 0 || px >= nx || py >= ny || pz >= nz) begin
                        continue;
                    end
                    id = px * ny * nz + py * nz + pz;
                    nbr.neighbor_id = ID_W'(id);
                    // hold one back so the final neighbor can be marked
                    if (have_held) begin
                        enqueue(held);
                    end
                    held = nbr;
                    have_held = 1'b1;
                end
            end
        end
        held.is_last = 1'b1;
        enqueue(held);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_x = CNT_W'(1);
            shadow_y = CNT_W'(1);
            shadow_z = CNT_W'(1);
            expected_cells.delete();
            o_fail_count = 0;
            o_results_seen = 0;
            done_seen = 1'b0;
        end else begin
            // results belong to older queries, so compare before queuing a new one
            if (i_strobe) begin
                o_results_seen++;
                if (expected_cells.size() == 0) begin
                    report($sformatf("result id %0d with nothing outstanding",
                                     i_result.neighbor_id));
                end else begin
                    want = expected_cells.pop_front();
                    check_field("neighbor_id", int'(i_result.neighbor_id),
                                int'(want.neighbor_id));
                    check_field("is_last", int'(i_result.is_last), int'(want.is_last));
                    check_field("out_of_grid", int'(i_result.out_of_grid),
                                int'(want.out_of_grid));
                    check_field("on_low_x", int'(i_result.on_low_x), int'(want.on_low_x));
                    check_field("on_low_y", int'(i_result.on_low_y), int'(want.on_low_y));
                    check_field("on_low_z", int'(i_result.on_low_z), int'(want.on_low_z));
                    check_field("on_high_x", int'(i_result.on_high_x), int'(want.on_high_x));
                    check_field("on_high_y", int'(i_result.on_high_y), int'(want.on_high_y));
                    check_field("on_high_z", int'(i_result.on_high_z), int'(want.on_high_z));
                end
            end
            if (i_start && !i_busy) begin
                predict_neighbors(i_query);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELLS_X: shadow_x = i_cfg_data;
                    CFG_CELLS_Y: shadow_y = i_cfg_data;
                    CFG_CELLS_Z: shadow_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (expected_cells.size() != 0) begin
                    report($sformatf("%0d results never arrived", expected_cells.size()));
                end
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

// ===== tb/tb_grid_cell_neighbor_enum_core.sv =====
// testbench top for the grid neighbor enumerator: stimulus, grid settings and verdict
`timescale 1ns / 1ps
module tb_grid_cell_neighbor_enum_core;
    import gcne_pkg::*;

    // index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int IDLE_LIMIT      = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_query                i_query;
    logic                  o_strobe;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  stim_done;

    int fail_count;
    int pending;
    int results_seen;
    int queries_sent;
    int grids_used;
    int idle_cycles;
    int grid_x;
    int grid_y;
    int grid_z;

    grid_cell_neighbor_enum_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_query    (i_query),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    gcne_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_query        (i_query),
        .i_strobe       (o_strobe),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_done         (stim_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always #6 i_clk = ~i_clk;

    // watchdog: cycles with neither a query transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("grid_cell_neighbor_enum_core verification failed");
                $finish;
            end
        end
    end

    function automatic int clamp_count(input logic [CNT_W-1:0] raw);
        return (int'(raw) > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : int'(raw);
    endfunction

    // mostly small grids so faces and corners come up often
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'($urandom_range(257, 511));
            2, 3:    return CNT_W'($urandom_range(7, 256));
            default: return CNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic int pick_coord(input int n);
        if (n == 0) begin
            return $urandom_range(0, 255);
        end
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    function automatic t_query random_query();
        t_query q;
        if ($urandom_range(0, 4) == 0) begin
            q.cell_x = COORD_W'($urandom_range(0, 255));
            q.cell_y = COORD_W'($urandom_range(0, 255));
            q.cell_z = COORD_W'($urandom_range(0, 255));
        end else begin
            q.cell_x = COORD_W'(pick_coord(grid_x));
            q.cell_y = COORD_W'(pick_coord(grid_y));
            q.cell_z = COORD_W'(pick_coord(grid_z));
        end
        return q;
    endfunction

    // holds start high until the transfer; returns at the next falling edge
    task automatic send_query(input t_query q);
        start <= 1'b1;
        i_query <= q;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queries_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        t_query q;
        q.cell_x = COORD_W'(x);
        q.cell_y = COORD_W'(y);
        q.cell_z = COORD_W'(z);
        send_query(q);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic set_grid(input logic [CNT_W-1:0] cx, input logic [CNT_W-1:0] cy,
                            input logic [CNT_W-1:0] cz, input bit spare);
        int rot;
        wait_idle();
        rot = $urandom_range(0, 2);
        if (spare) begin
            write_count(CFG_SPARE, CNT_W'($urandom_range(0, 511)));
        end
        for (int k = 0; k < 3; k++) begin
            case ((k + rot) % 3)
                0:       write_count(CFG_CELLS_X, cx);
                1:       write_count(CFG_CELLS_Y, cy);
                default: write_count(CFG_CELLS_Z, cz);
            endcase
        end
        i_cfg_we <= 1'b0;
        grid_x = clamp_count(cx);
        grid_y = clamp_count(cy);
        grid_z = clamp_count(cz);
        grids_used++;
    endtask

    initial begin
        int sent;
        int burst;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_query = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        stim_done = 1'b0;
        queries_sent = 0;
        grids_used = 1;
        grid_x = 1;
        grid_y = 1;
        grid_z = 1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset grid is one cell: only the origin is inside
        send_xyz(0, 0, 0);
        send_xyz(0, 0, 1);
        send_xyz(255, 255, 255);

        set_grid(9'd3, 9'd3, 9'd3, 1'b0);
        send_xyz(0, 0, 0);
        send_xyz(1, 1, 1);
        send_xyz(2, 2, 2);
        send_xyz(2, 0, 1);
        send_xyz(3, 0, 0);
        send_xyz(0, 3, 0);
        send_xyz(0, 0, 3);

        // counts above the axis limit saturate, largest id at the far corner
        set_grid(9'd511, 9'd256, 9'd257, 1'b0);
        send_xyz(255, 255, 255);
        send_xyz(0, 0, 0);
        send_xyz(128, 255, 0);
        send_xyz(8'haa, 8'h55, 8'hf0);

        // zero count puts everything outside
        set_grid(9'd0, 9'd4, 9'd4, 1'b0);
        send_xyz(0, 0, 0);

        set_grid(9'd1, 9'd256, 9'd1, 1'b0);
        send_xyz(0, 255, 0);

        // spare index write must leave the counts alone
        set_grid(9'd2, 9'd1, 9'd5, 1'b1);
        send_xyz(1, 0, 4);
        send_xyz(0, 0, 2);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_grid(pick_count(), pick_count(), pick_count(), $urandom_range(0, 2) == 0);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
                    send_query(random_query());
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0:       wait_idle();
                    1, 2, 3: ;
                    default: pause($urandom_range(1, 12));
                endcase
            end
        end

        wait_idle();
        repeat (40) @(negedge i_clk);
        stim_done <= 1'b1;
        repeat (2) @(negedge i_clk);
        $display("covered %0d queries over %0d grid settings, %0d neighbor results compared",
                 queries_sent, grids_used, results_seen);
        $display("included corner, face, zero-count and saturated grids with bursty starts");
        if (fail_count == 0) begin
            $display("grid_cell_neighbor_enum_core verification clean");
        end else begin
            $display("grid_cell_neighbor_enum_core verification failed");
        end
        $finish;
    end

endmodule
